>>> hw/rtl/sis_pdu_trailer_crc12_assert.svh
// Assertion macros for the SIS PDU trailer CRC12 block.
`ifndef SIS_PDU_TRAILER_CRC12_ASSERT_SVH
`define SIS_PDU_TRAILER_CRC12_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sptc_pkg.sv
// Package: types, constants and CRC helpers for the SIS PDU trailer block.
`default_nettype none

package sptc_pkg;

    localparam int PAYLOAD_W   = 64;
    localparam int CRC_W       = 12;
    localparam int CRC_REG_W   = 16;
    localparam int CRC_IN_W    = 68;
    localparam int FRAME_W     = 32;
    localparam int BLK_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int FM_BLOCKS_DEF = 16;
    localparam int AM_BLOCKS_DEF = 8;

    localparam logic [CRC_REG_W-1:0] CRC_POLY     = 16'hD010;
    localparam logic [CRC_W-1:0]     CRC_XOR      = 12'h955;
    localparam logic [FRAME_W-1:0]   FRAME_START0 = 32'd800000000;
    localparam logic [5:0]           AM_UPPER_OFS = 6'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AM_MODE     = 2'd0,
        CFG_TIME_STATUS = 2'd1,
        CFG_FRAME_START = 2'd2
    } t_cfg_idx;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 ts_flag;
        logic [1:0]           frame_pair;
        logic [BLK_W-1:0]     block_number;
        logic                 frame_end;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef logic [CRC_W-1:0] t_crc_cols [CRC_IN_W];

    function automatic logic [CRC_REG_W-1:0] crc_step(logic [CRC_REG_W-1:0] r, logic b);
        logic                 low;
        logic [CRC_REG_W-1:0] n;
        low = r[0];
        n   = {b, r[CRC_REG_W-1:1]};
        if (low) begin
            n = n ^ CRC_POLY;
        end
        return n;
    endfunction

    // Contribution of each input bit to the final CRC (linear, zero start).
    function automatic t_crc_cols crc_cols_calc();
        t_crc_cols            cols;
        logic [CRC_REG_W-1:0] r;
        for (int j = 0; j < CRC_IN_W; j++) begin
            r = '0;
            for (int k = 0; k < CRC_IN_W; k++) begin
                r = crc_step(r, (k == j));
            end
            for (int k = 0; k < CRC_REG_W; k++) begin
                r = crc_step(r, 1'b0);
            end
            cols[j] = r[CRC_W-1:0];
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_cols_calc();

    // Bit j of w is the j-th bit fed into the register.
    function automatic logic [CRC_W-1:0] crc12(logic [CRC_IN_W-1:0] w);
        logic [CRC_W-1:0] acc;
        acc = CRC_XOR;
        for (int j = 0; j < CRC_IN_W; j++) begin
            if (w[j]) begin
                acc = acc ^ CRC_COLS[j];
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sis_pdu_trailer_crc12.sv
// An accepted item is written into the queue, then loaded into the result register
// that drives the result ports. One item per cycle while pop keeps up; a two-entry queue
// between classifier and CRC stage plus the result register buffer items under stalls.
// The CRC is a constant XOR tree over the 68 head bits, registered in the back stage.
// Reset (synchronous, active low): queue and result empty, FM mode, time status 0,
// frame number 800000000, block counter 0.
`default_nettype none

module sis_pdu_trailer_crc12 #(
    parameter int FM_BLOCKS = sptc_pkg::FM_BLOCKS_DEF,
    parameter int AM_BLOCKS = sptc_pkg::AM_BLOCKS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [sptc_pkg::PAYLOAD_W-1:0]   i_payload_bits,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [sptc_pkg::PAYLOAD_W-1:0]        o_payload_out,
    output logic                                  o_time_status,
    output logic [1:0]                            o_frame_pair,
    output logic [sptc_pkg::CRC_W-1:0]            o_crc_value,
    output logic [sptc_pkg::BLK_W-1:0]            o_block_number,
    output logic                                  o_frame_end,
    input  wire logic                             i_cfg_we,
    input  wire logic [sptc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sptc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    sptc_pkg::t_item            front_item;
    sptc_pkg::t_item            q_item;
    sptc_pkg::t_item            out_item;
    sptc_pkg::t_q_stat          q_stat;
    logic                       accept;
    logic                       q_rd;
    logic                       out_valid;
    logic [sptc_pkg::CRC_W-1:0] chk_crc;

    assign accept = push && !q_stat.full;

    sptc_front #(
        .FM_BLOCKS (FM_BLOCKS),
        .AM_BLOCKS (AM_BLOCKS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_payload  (i_payload_bits),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_item     (front_item)
    );

    sptc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_item  (front_item),
        .i_rd    (q_rd),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    sptc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_item   (q_item),
        .i_pop    (pop),
        .o_q_rd   (q_rd),
        .o_valid  (out_valid),
        .o_item   (out_item),
        .o_crc    (o_crc_value)
    );

    assign full           = q_stat.full;
    assign empty          = !out_valid;
    assign o_payload_out  = out_item.payload;
    assign o_time_status  = out_item.ts_flag;
    assign o_frame_pair   = out_item.frame_pair;
    assign o_block_number = out_item.block_number;
    assign o_frame_end    = out_item.frame_end;

    assign chk_crc = sptc_pkg::crc12({o_payload_out, 1'b0, o_time_status, o_frame_pair});

`include "sis_pdu_trailer_crc12_assert.svh"

    // an accepted item lands in the queue
    `SPTC_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, accept, !q_stat.empty, "item lost")
    // a non-empty queue is followed by a valid result register
    `SPTC_ASSERT_NEXT(a_queue_drains, i_clk, i_rst_n, !q_stat.empty, !empty, "result starved")
    // result CRC matches the fields it was built from
    `SPTC_ASSERT_NOW(a_crc_match, i_clk, i_rst_n, !empty, o_crc_value == chk_crc, "crc mismatch")

endmodule

`default_nettype wire

>>> hw/rtl/sptc_front.sv
// Front end: config registers, block/frame counters, item classification.
`default_nettype none

module sptc_front #(
    parameter int FM_BLOCKS = sptc_pkg::FM_BLOCKS_DEF,
    parameter int AM_BLOCKS = sptc_pkg::AM_BLOCKS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic [sptc_pkg::PAYLOAD_W-1:0]   i_payload,
    input  wire logic                             i_cfg_we,
    input  wire logic [sptc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sptc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sptc_pkg::t_item                       o_item
);

    localparam logic [sptc_pkg::BLK_W:0] FM_CNT = (sptc_pkg::BLK_W+1)'(FM_BLOCKS);
    localparam logic [sptc_pkg::BLK_W:0] AM_CNT = (sptc_pkg::BLK_W+1)'(AM_BLOCKS);

    logic                            r_am_mode;
    logic                            r_ts;
    logic [sptc_pkg::FRAME_W-1:0]    r_frame;
    logic [sptc_pkg::BLK_W-1:0]      r_blk;
    logic [sptc_pkg::FRAME_W-1:0]    n_frame;
    logic [sptc_pkg::BLK_W-1:0]      n_blk;

    logic [2*sptc_pkg::FRAME_W-1:0]  frame_ext;
    logic [5:0]                      shift;
    logic [sptc_pkg::BLK_W:0]        blocks;
    logic                            last;
    logic                            start_wr;

    always_comb begin
        blocks    = r_am_mode ? AM_CNT : FM_CNT;
        last      = ({1'b0, r_blk} + 1'b1) >= blocks;
        // AM sends the upper pair on frames that are a multiple of four
        shift     = {1'b0, r_blk, 1'b0};
        if (r_am_mode && (r_frame[1:0] == 2'b00)) begin
            shift = shift + sptc_pkg::AM_UPPER_OFS;
        end
        frame_ext = {{sptc_pkg::FRAME_W{1'b0}}, r_frame};

        o_item.payload      = i_payload;
        o_item.ts_flag      = r_ts;
        o_item.frame_pair   = frame_ext[shift +: 2];
        o_item.block_number = r_blk;
        o_item.frame_end    = last;
    end

    assign start_wr = i_cfg_we && (i_cfg_idx == sptc_pkg::CFG_FRAME_START);

    always_comb begin
        n_frame = r_frame;
        n_blk   = r_blk;
        if (i_accept) begin
            if (last) begin
                n_blk   = '0;
                n_frame = r_frame + 1'b1;
            end else begin
                n_blk   = r_blk + 1'b1;
            end
        end else if (start_wr && (r_blk == '0)) begin
            n_frame = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_am_mode <= 1'b0;
            r_ts      <= 1'b0;
            r_frame   <= sptc_pkg::FRAME_START0;
            r_blk     <= '0;
        end else begin
            r_frame <= n_frame;
            r_blk   <= n_blk;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sptc_pkg::CFG_AM_MODE:     r_am_mode <= i_cfg_data[0];
                    sptc_pkg::CFG_TIME_STATUS: r_ts      <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sptc_queue.sv
// Short item queue between front and back.
`default_nettype none

module sptc_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire sptc_pkg::t_item   i_item,
    input  wire logic              i_rd,
    output sptc_pkg::t_item        o_item,
    output sptc_pkg::t_q_stat      o_stat
);

    localparam int PTR_W = $clog2(sptc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sptc_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(sptc_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(sptc_pkg::QUEUE_DEPTH - 1);

    sptc_pkg::t_item       r_slot [sptc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  wr_en;
    logic                  rd_en;

    assign o_stat.full  = (r_count == DEPTH_CNT);
    assign o_stat.empty = (r_count == '0);
    assign wr_en        = i_wr && !o_stat.full;
    assign rd_en        = i_rd && !o_stat.empty;
    assign o_item       = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sptc_back.sv
// Back end: CRC over the completed PDU head and the result register.
`default_nettype none

module sptc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sptc_pkg::t_q_stat            i_q_stat,
    input  wire sptc_pkg::t_item              i_item,
    input  wire logic                         i_pop,
    output logic                              o_q_rd,
    output logic                              o_valid,
    output sptc_pkg::t_item                   o_item,
    output logic [sptc_pkg::CRC_W-1:0]        o_crc
);

    logic                       r_valid;
    logic                       n_valid;
    sptc_pkg::t_item            r_item;
    logic [sptc_pkg::CRC_W-1:0] r_crc;
    logic                       load;
    logic [sptc_pkg::CRC_IN_W-1:0] crc_word;

    assign load    = !i_q_stat.empty && (!r_valid || i_pop);
    assign o_q_rd  = load;
    // reserved zero, then time status, then frame pair
    assign crc_word = {i_item.payload, 1'b0, i_item.ts_flag, i_item.frame_pair};

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
            r_crc  <= sptc_pkg::crc12(crc_word);
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_crc   = r_crc;

endmodule

`default_nettype wire
